@@ rtl/drt_pkg.sv @@
// shared types and constants for the dirty row run tracker
`timescale 1ns / 1ps

package drt_pkg;

  localparam int ROW_W = 7;
  localparam int CNT_W = 8;

  localparam logic [1:0] OP_MARK  = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [CNT_W-1:0] ROWS_IN_USE_RESET = 8'd128;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [ROW_W-1:0] row_first;
    logic [ROW_W-1:0] row_last;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0] run_start;
    logic [CNT_W-1:0] run_count;
    logic             last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic mark;
    logic wipe;
    logic load;
    logic step;
    logic drain;
  } dp_cmd_t;

  typedef struct packed {
    logic any_dirty;
    logic scan_end;
  } dp_status_t;

endpackage

@@ rtl/drt_ctrl.sv @@
// controller state machine: decodes words and sequences the flush scan
`timescale 1ns / 1ps

module drt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         opcode,
  input  drt_pkg::dp_status_t status,
  output drt_pkg::dp_cmd_t   cmd,
  output logic               busy
);

  drt_pkg::state_t state;
  drt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      drt_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (opcode)
            drt_pkg::OP_MARK:  cmd.mark = 1'b1;
            drt_pkg::OP_CLEAR: cmd.wipe = 1'b1;
            drt_pkg::OP_FLUSH: begin
              if (status.any_dirty) begin
                cmd.load   = 1'b1;
                state_next = drt_pkg::ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      drt_pkg::ST_SCAN: begin
        cmd.step = 1'b1;
        if (status.scan_end) begin
          state_next = drt_pkg::ST_DRAIN;
        end
      end
      drt_pkg::ST_DRAIN: begin
        cmd.drain  = 1'b1;
        state_next = drt_pkg::ST_IDLE;
      end
      default: begin
        state_next = drt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/drt_datapath.sv @@
// datapath: dirty bitmap, row scan shifter, run builder and result register
`timescale 1ns / 1ps

module drt_datapath #(
  parameter int ROWS = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  input  drt_pkg::item_t            item,
  input  drt_pkg::dp_cmd_t          cmd,
  input  logic                      cfg_valid,
  input  logic [drt_pkg::CNT_W-1:0] cfg_data,
  output drt_pkg::dp_status_t       status,
  output logic                      result_valid,
  output drt_pkg::result_t          result
);

  localparam logic [drt_pkg::CNT_W-1:0] ROWS_MAX = drt_pkg::CNT_W'(ROWS);

  logic [drt_pkg::CNT_W-1:0] rows_in_use;
  logic [drt_pkg::CNT_W-1:0] active;
  logic [drt_pkg::CNT_W-1:0] last_row;
  logic [drt_pkg::CNT_W-1:0] first_row;
  logic [ROWS-1:0]           dirty;
  logic [ROWS-1:0]           mark_mask;
  logic                      any_dirty;
  logic [ROWS-1:0]           scan;
  logic [drt_pkg::CNT_W-1:0] row_idx;
  logic                      in_run;
  logic [drt_pkg::ROW_W-1:0] run_start;
  logic                      pend_valid;
  logic [drt_pkg::ROW_W-1:0] pend_start;
  logic [drt_pkg::CNT_W-1:0] pend_count;
  logic                      row_dirty;
  logic                      run_close;

  always_comb begin
    if (rows_in_use == '0) begin
      active = 8'd1;
    end else if (rows_in_use > ROWS_MAX) begin
      active = ROWS_MAX;
    end else begin
      active = rows_in_use;
    end
  end

  assign first_row = {1'b0, item.row_first};

  always_comb begin
    if ({1'b0, item.row_last} > (active - 8'd1)) begin
      last_row = active - 8'd1;
    end else begin
      last_row = {1'b0, item.row_last};
    end
  end

  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      mark_mask[i] = (drt_pkg::CNT_W'(i) >= first_row) && (drt_pkg::CNT_W'(i) <= last_row);
    end
  end

  assign row_dirty        = (row_idx < active) && scan[0];
  assign run_close        = in_run && !row_dirty;
  assign status.any_dirty = any_dirty;
  assign status.scan_end  = (row_idx == active);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= drt_pkg::ROWS_IN_USE_RESET;
    end else if (cfg_valid) begin
      rows_in_use <= cfg_data;
    end
  end

  // bitmap and flag
  always_ff @(posedge clk) begin
    if (rst) begin
      dirty     <= '0;
      any_dirty <= 1'b0;
    end else if (cmd.wipe || cmd.load) begin
      dirty     <= '0;
      any_dirty <= 1'b0;
    end else if (cmd.mark && (first_row <= last_row)) begin
      dirty     <= dirty | mark_mask;
      any_dirty <= 1'b1;
    end
  end

  // scan and run building
  always_ff @(posedge clk) begin
    if (rst) begin
      in_run     <= 1'b0;
      pend_valid <= 1'b0;
    end else if (cmd.load) begin
      in_run     <= 1'b0;
      pend_valid <= 1'b0;
    end else if (cmd.step) begin
      if (!in_run && row_dirty) begin
        in_run <= 1'b1;
      end else if (run_close) begin
        in_run     <= 1'b0;
        pend_valid <= 1'b1;
      end
    end else if (cmd.drain) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan    <= dirty;
      row_idx <= '0;
    end else if (cmd.step) begin
      scan    <= {1'b0, scan[ROWS-1:1]};
      row_idx <= row_idx + 8'd1;
      if (!in_run && row_dirty) begin
        run_start <= row_idx[drt_pkg::ROW_W-1:0];
      end
      if (run_close) begin
        pend_start <= run_start;
        pend_count <= row_idx - {1'b0, run_start};
      end
    end
  end

  // result word, one cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.step && run_close && pend_valid) || (cmd.drain && pend_valid);
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.step && run_close) || cmd.drain) begin
      result.run_start <= pend_start;
      result.run_count <= pend_count;
      result.last      <= cmd.drain;
    end
  end

endmodule

@@ rtl/dirty_row_run_tracker.sv @@
// top level of the dirty row run tracker
`timescale 1ns / 1ps

// Tracks one dirty bit per surface row and reports runs of dirty rows.
// Input: a word is taken on a rising edge with start high and busy low.
//   mark (row_first..row_last, last row clamped to rows in use) and clear
//   take effect as the word is taken; busy stays low.
// Flush: if any row was marked, busy rises and a one-row-per-cycle shifter
//   walks the rows in use. Each run is reported as result_valid for one
//   cycle with run_start and run_count; the final run carries last.
//   With N the rows in use held to 1..ROWS, busy stays high while the
//   shifter walks row indices 0..N and through the drain state after it;
//   results trail their run end by one run, the final one comes out in
//   the first cycle with busy low.
//   A flush with nothing marked leaves busy low and reports nothing.
// Config: cfg_valid with cfg_ready (always high) writes rows_in_use; the
//   user must do so only while the block is idle; it is not enforced.
// Reset (rst, synchronous): bitmap and flag cleared, rows_in_use = 128.
// The receiver cannot stall; every result word is taken in its cycle.
module dirty_row_run_tracker #(
  parameter int ROWS = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  drt_pkg::item_t            item,
  output logic                      result_valid,
  output drt_pkg::result_t          result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [drt_pkg::CNT_W-1:0] cfg_data
);

  drt_pkg::dp_cmd_t    cmd;
  drt_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  drt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (item.opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  drt_datapath #(
    .ROWS (ROWS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

@@ rtl/drt_checker.sv @@
// port level checks for the dirty row run tracker
`timescale 1ns / 1ps

module drt_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input drt_pkg::item_t   item,
  input logic             result_valid,
  input drt_pkg::result_t result
);

  a_idle_word_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !busy) |-> result.last)
    else $error("result after flush end not marked last");

  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> busy)
    else $error("non-final run while idle");

  a_from_flush: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a flush in progress");

  a_nonzero_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.run_count != 8'd0))
    else $error("empty run reported");

  a_mark_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.opcode != drt_pkg::OP_FLUSH)) |=> !busy)
    else $error("mark or clear made the block busy");

endmodule

bind dirty_row_run_tracker drt_checker u_drt_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .item         (item),
  .result_valid (result_valid),
  .result       (result)
);

@@ bench/tb_top.sv @@
// self-checking testbench for the dirty row run tracker
`timescale 1ns / 1ps

module tb_top;

  localparam int ROWS = 128;
  localparam int LIMIT = 300000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class run_tracker_model;
    bit [ROWS-1:0] dirty;
    bit any_dirty;
    int unsigned rows_active;
    drt_pkg::result_t expected_runs[$];
    int errors;
    int runs_checked;

    function new();
      rows_active = ROWS;
    endfunction

    function void set_rows(logic [drt_pkg::CNT_W-1:0] v);
      if (v == 0) begin
        rows_active = 1;
      end else if (v > ROWS) begin
        rows_active = ROWS;
      end else begin
        rows_active = v;
      end
    endfunction

    function void note_word(drt_pkg::item_t w);
      int unsigned top, r, run_from;
      bit in_run, d, have_held;
      drt_pkg::result_t held, run;
      case (w.opcode)
        drt_pkg::OP_MARK: begin
          top = (w.row_last > rows_active - 1) ? rows_active - 1 : w.row_last;
          if (w.row_first <= top) begin
            for (r = w.row_first; r <= top; r++) dirty[r] = 1'b1;
            any_dirty = 1'b1;
          end
        end
        drt_pkg::OP_FLUSH: begin
          if (any_dirty) begin
            in_run = 1'b0;
            have_held = 1'b0;
            run_from = 0;
            for (r = 0; r <= rows_active; r++) begin
              d = (r < rows_active) ? dirty[r] : 1'b0;
              if (!in_run && d) begin
                in_run = 1'b1;
                run_from = r;
              end else if (in_run && !d) begin
                in_run = 1'b0;
                run.run_start = drt_pkg::ROW_W'(run_from);
                run.run_count = drt_pkg::CNT_W'(r - run_from);
                run.last = 1'b0;
                if (have_held) expected_runs.push_back(held);
                held = run;
                have_held = 1'b1;
              end
            end
            if (have_held) begin
              held.last = 1'b1;
              expected_runs.push_back(held);
            end
            dirty = '0;
            any_dirty = 1'b0;
          end
        end
        drt_pkg::OP_CLEAR: begin
          dirty = '0;
          any_dirty = 1'b0;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_run(drt_pkg::result_t got);
      drt_pkg::result_t want;
      if (expected_runs.size() == 0) begin
        errors++;
        $error("unexpected run: run_start %0d run_count %0d last %0d",
               got.run_start, got.run_count, got.last);
        return;
      end
      want = expected_runs.pop_front();
      runs_checked++;
      if (got.run_start !== want.run_start) begin
        errors++;
        $error("run_start expected %0d actual %0d", want.run_start, got.run_start);
      end
      if (got.run_count !== want.run_count) begin
        errors++;
        $error("run_count expected %0d actual %0d", want.run_count, got.run_count);
      end
      if (got.last !== want.last) begin
        errors++;
        $error("last expected %0d actual %0d", want.last, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  drt_pkg::item_t item = '0;
  logic result_valid;
  drt_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [drt_pkg::CNT_W-1:0] cfg_data = '0;

  run_tracker_model board = new();
  int cycles = 0;
  int words_sent = 0;
  int settings_used = 0;
  bit eager = 1'b0;

  dirty_row_run_tracker #(.ROWS(ROWS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid) board.check_run(result);
  end

  // called and returns at a falling edge; start stays high for a following word
  task automatic send(logic [1:0] op, int first, int lastrow);
    drt_pkg::item_t w;
    int gap;
    bit taken;
    w.opcode = op;
    w.row_first = drt_pkg::ROW_W'(first);
    w.row_last = drt_pkg::ROW_W'(lastrow);
    gap = eager ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item <= w;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      if (taken) begin
        board.note_word(w);
        words_sent++;
      end
      @(negedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (board.expected_runs.size() != 0) @(negedge clk);
    repeat (ROWS + 4) @(negedge clk);
  endtask

  task automatic write_rows(logic [drt_pkg::CNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    board.set_rows(v);
    settings_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int words);
    int base, k, i, n, first, lastrow, style;
    bit comb;
    base = words_sent;
    eager = ($urandom_range(0, 3) == 0);
    while (words_sent - base < words) begin
      n = board.rows_active;
      if ($urandom_range(0, 9) < 8) begin
        comb = ($urandom_range(0, 5) == 0);
        k = comb ? $urandom_range(8, 20) : $urandom_range(1, 5);
        for (i = 0; i < k; i++) begin
          style = comb ? 1 : $urandom_range(0, 3);
          first = $urandom_range(0, n - 1);
          case (style)
            0: begin
              lastrow = first + $urandom_range(0, 3);
              if (lastrow > ROWS - 1) lastrow = ROWS - 1;
            end
            1: lastrow = first;
            2: lastrow = $urandom_range(0, ROWS - 1);
            default: begin
              first = $urandom_range(0, ROWS - 1);
              lastrow = $urandom_range(0, ROWS - 1);
            end
          endcase
          send(drt_pkg::OP_MARK, first, lastrow);
        end
        if ($urandom_range(0, 7) == 0) send(drt_pkg::OP_CLEAR, $urandom_range(0, 127), 0);
        send(drt_pkg::OP_FLUSH, $urandom_range(0, 127), $urandom_range(0, 127));
      end else begin
        send(2'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom_range(0, 127));
      end
    end
  endtask

  initial begin
    logic [drt_pkg::CNT_W-1:0] settings[8];
    int p;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_rows(drt_pkg::ROWS_IN_USE_RESET);
    send(drt_pkg::OP_FLUSH, 0, 0);
    send(drt_pkg::OP_MARK, 0, 0);
    send(drt_pkg::OP_MARK, 127, 127);
    send(drt_pkg::OP_MARK, 5, 9);
    send(drt_pkg::OP_MARK, 9, 5);
    send(drt_pkg::OP_MARK, 10, 10);
    send(drt_pkg::OP_FLUSH, 127, 127);
    send(drt_pkg::OP_MARK, 0, 127);
    send(drt_pkg::OP_FLUSH, 0, 0);
    send(drt_pkg::OP_MARK, 20, 30);
    send(drt_pkg::OP_CLEAR, 0, 0);
    send(drt_pkg::OP_FLUSH, 0, 0);
    send(drt_pkg::OP_MARK, 40, 40);
    send(OP_UNUSED, 0, 127);
    send(drt_pkg::OP_FLUSH, 0, 0);
    // rows above a smaller setting are dropped by the flush
    send(drt_pkg::OP_MARK, 60, 70);
    settle();
    write_rows(8'd16);
    send(drt_pkg::OP_FLUSH, 0, 0);
    settle();
    write_rows(8'd128);
    send(drt_pkg::OP_FLUSH, 0, 0);
    settle();
    write_rows(8'd4);
    send(drt_pkg::OP_MARK, 2, 127);
    send(drt_pkg::OP_MARK, 100, 127);
    send(drt_pkg::OP_FLUSH, 0, 0);

    settings = '{8'd0, 8'd1, 8'd2, 8'd255, 8'd200, 8'd128, 8'd64, 8'd0};
    settings[7] = drt_pkg::CNT_W'($urandom_range(3, 127));
    for (p = 0; p < 8; p++) begin
      settle();
      write_rows(settings[p]);
      random_phase(10);
    end

    settle();
    $display("%0d words sent over %0d row settings, %0d runs checked",
             words_sent, settings_used, board.runs_checked);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/drt_pkg.sv
rtl/drt_ctrl.sv
rtl/drt_datapath.sv
rtl/dirty_row_run_tracker.sv
rtl/drt_checker.sv
bench/tb_top.sv
